// File: rtl/wfv_pkg.sv
// Shared constants and types for the waypoint follower velocity block.
package wfv_pkg;

    localparam int MAX_WAYPOINTS = 128;
    localparam int IDX_W         = $clog2(MAX_WAYPOINTS);
    localparam int TOTAL_W       = IDX_W + 1;
    localparam int COORD_W       = 32;
    localparam int SPEED_W       = 32;
    localparam int ENTRY_W       = 2 * COORD_W + SPEED_W;
    localparam int IN_DATA_W     = 96;
    localparam int OUT_DATA_W    = 80;
    localparam int PADDR_W       = 4;
    localparam int PDATA_W       = 64;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_TICK  = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } opcode_t;

    // register index taken from paddr[3]
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_LOOP      = 1'b1;

    typedef struct packed {
        logic        table_full;
        logic        done_res;
        logic [6:0]  reached_index;
        logic        reached;
        logic [31:0] velocity_y;
        logic [31:0] velocity_x;
        logic        drive_valid;
    } result_t;

endpackage

// File: rtl/wfv_ram.sv
// Generic single-port synchronous RAM with registered read.
module wfv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/waypoint_follower_velocity_top.sv
// Waypoint follower: table of Q16.16 waypoints and speeds, tick-driven velocity command.
//
// One request at a time. Add, start and stop, and a tick that finds motion stopped or the
// table empty, go from the execute state straight to the output stage. A tick with motion
// active first reads the target from memory, then does four squarings and two products on
// one shared 32x32 multiplier, then a bit-per-cycle square root and two bit-per-cycle
// dividers working in parallel. A tick that finishes the path skips the direction work and
// goes to the output stage right after the compare.
// A result held back by m_tready stalls the block in its output stage. A new request is
// taken as soon as the previous one has moved into the output register.
// The threshold register sits at byte address 0 (64 bits), loop enable at address 8.
module waypoint_follower_velocity_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [wfv_pkg::IN_DATA_W-1:0]    s_tdata,  // coord_x, coord_y, move_speed
    input  logic [1:0]                       s_tuser,  // opcode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // drive_valid, velocity_x, velocity_y, reached, reached_index, done_res,
    // table_full, zero pad
    output logic [wfv_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wfv_pkg::PADDR_W-1:0]      paddr,
    input  logic [wfv_pkg::PDATA_W-1:0]      pwdata,
    output logic [wfv_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);

    import wfv_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_LOAD, S_SQX, S_SQY, S_CMP, S_MX, S_MY,
        S_ROOT, S_NX, S_NY, S_DIV, S_FIN, S_OUT
    } state_t;

    state_t               state_reg;
    opcode_t              op_reg;
    logic [31:0]          cx_reg, cy_reg, spd_in_reg;
    logic [63:0]          thr_reg;
    logic                 loop_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic [IDX_W-1:0]     cur_reg;
    logic                 fin_reg;
    result_t              res_reg;
    result_t              out_reg;
    logic                 m_tvalid_reg;

    logic signed [32:0]   dx_reg, dy_reg;
    logic [31:0]          spd_reg;
    logic [63:0]          sx_reg, sy_reg, sq_reg;
    logic [63:0]          rad_reg;
    logic [34:0]          rem_reg;
    logic [31:0]          root_reg;
    logic [4:0]           cnt_reg;
    logic [31:0]          remx_reg, remy_reg, lox_reg, loy_reg, qx_reg, qy_reg;
    logic                 ovfx_reg, ovfy_reg;

    // memory
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_addr;
    logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;

    wfv_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_WAYPOINTS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign ram_we    = (state_reg == S_EXEC) && (op_reg == OP_ADD) &&
                       (total_reg < TOTAL_W'(MAX_WAYPOINTS));
    assign ram_addr  = (state_reg == S_EXEC && op_reg == OP_ADD) ?
                       total_reg[IDX_W-1:0] : cur_reg;
    assign ram_wdata = {spd_in_reg, cy_reg, cx_reg};

    // configuration port
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[3] == REG_LOOP) ? {{(PDATA_W-1){1'b0}}, loop_reg} : thr_reg;

    // datapath helpers
    logic [32:0] ax_w, ay_w;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [64:0] ssum;
    logic [63:0] s_sat;
    logic        cmp_hit;
    logic        halve;
    logic [34:0] rem_sh, trial;
    logic [32:0] tx, ty;
    logic        mag_zero;

    assign ax_w = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
    assign ay_w = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);

    always_comb
    begin
        mul_a = ax_w[31:0];
        mul_b = ax_w[31:0];
        case (state_reg)
            S_SQY, S_MY:
            begin
                mul_a = ay_w[31:0];
                mul_b = ay_w[31:0];
            end
            S_NX:
            begin
                mul_a = ax_w[31:0];
                mul_b = spd_reg;
            end
            S_NY:
            begin
                mul_a = ay_w[31:0];
                mul_b = spd_reg;
            end
            default:
            begin
                mul_a = ax_w[31:0];
                mul_b = ax_w[31:0];
            end
        endcase
    end

    assign prod    = {32'd0, mul_a} * {32'd0, mul_b};
    assign ssum    = {1'b0, sx_reg} + {1'b0, sy_reg};
    assign s_sat   = ssum[64] ? '1 : ssum[63:0];
    assign cmp_hit = (s_sat < thr_reg);
    assign halve   = ax_w[32] || ax_w[31] || ay_w[32] || ay_w[31];
    assign rem_sh  = {rem_reg[32:0], rad_reg[63:62]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign tx      = {remx_reg, lox_reg[31]};
    assign ty      = {remy_reg, loy_reg[31]};
    assign mag_zero = (root_reg == 32'd0);

    function automatic logic [31:0] sat_vel(input logic neg, input logic [31:0] q,
                                            input logic ovf, input logic mz);
        logic [31:0] r;
        if (mz)
            r = 32'd0;
        else if (!neg)
            r = (ovf || q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
        else
            r = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q);
        return r;
    endfunction

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            thr_reg      <= 64'h1_0000_0000;
            loop_reg     <= 1'b0;
            total_reg    <= '0;
            cur_reg      <= '0;
            fin_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            op_reg       <= OP_ADD;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (paddr[3] == REG_THRESHOLD)
                    thr_reg <= pwdata;
                else
                    loop_reg <= pwdata[0];
            end
            if (m_tvalid_reg && m_tready && state_reg != S_OUT)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg     <= opcode_t'(s_tuser);
                        cx_reg     <= s_tdata[31:0];
                        cy_reg     <= s_tdata[63:32];
                        spd_in_reg <= s_tdata[95:64];
                        state_reg  <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    res_reg <= {(op_reg == OP_ADD) && !(total_reg < TOTAL_W'(MAX_WAYPOINTS)),
                                {($bits(result_t) - 1){1'b0}}};
                    case (op_reg)
                        OP_ADD:
                        begin
                            if (total_reg < TOTAL_W'(MAX_WAYPOINTS))
                                total_reg <= total_reg + 1'b1;
                            state_reg <= S_OUT;
                        end
                        OP_START:
                        begin
                            fin_reg   <= 1'b0;
                            state_reg <= S_OUT;
                        end
                        OP_STOP:
                        begin
                            fin_reg   <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        default:
                        begin
                            if (!fin_reg && total_reg != '0)
                                state_reg <= S_LOAD;
                            else
                                state_reg <= S_OUT;
                        end
                    endcase
                end
                S_LOAD:
                begin
                    dx_reg    <= {ram_rdata[31], ram_rdata[31:0]} - {cx_reg[31], cx_reg};
                    dy_reg    <= {ram_rdata[63], ram_rdata[63:32]} - {cy_reg[31], cy_reg};
                    spd_reg   <= ram_rdata[95:64];
                    state_reg <= S_SQX;
                end
                S_SQX:
                begin
                    sx_reg    <= ax_w[32] ? '1 : prod;
                    state_reg <= S_SQY;
                end
                S_SQY:
                begin
                    sy_reg    <= ay_w[32] ? '1 : prod;
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    res_reg <= {res_reg.table_full, res_reg.done_res,
                                cmp_hit ? 7'(cur_reg) : 7'd0, cmp_hit,
                                res_reg.velocity_y, res_reg.velocity_x, 1'b1};
                    if (halve)
                    begin
                        dx_reg <= dx_reg >>> 1;
                        dy_reg <= dy_reg >>> 1;
                    end
                    if (cmp_hit)
                    begin
                        if (TOTAL_W'(cur_reg) + 1'b1 >= total_reg)
                        begin
                            cur_reg <= '0;
                            if (!loop_reg)
                            begin
                                // finish: zero velocity, skip the direction work
                                fin_reg   <= 1'b1;
                                state_reg <= S_OUT;
                            end
                            else
                                state_reg <= S_MX;
                        end
                        else
                        begin
                            cur_reg   <= cur_reg + 1'b1;
                            state_reg <= S_MX;
                        end
                    end
                    else
                        state_reg <= S_MX;
                end
                S_MX:
                begin
                    sq_reg    <= prod;
                    state_reg <= S_MY;
                end
                S_MY:
                begin
                    rad_reg   <= sq_reg + prod;
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    rad_reg <= {rad_reg[61:0], 2'b00};
                    if (rem_sh >= trial)
                    begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd31)
                        state_reg <= S_NX;
                end
                S_NX:
                begin
                    remx_reg  <= prod[63:32];
                    lox_reg   <= prod[31:0];
                    ovfx_reg  <= prod[63:32] >= root_reg;
                    state_reg <= S_NY;
                end
                S_NY:
                begin
                    remy_reg  <= prod[63:32];
                    loy_reg   <= prod[31:0];
                    ovfy_reg  <= prod[63:32] >= root_reg;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    lox_reg <= {lox_reg[30:0], 1'b0};
                    loy_reg <= {loy_reg[30:0], 1'b0};
                    if (tx >= {1'b0, root_reg})
                    begin
                        remx_reg <= 32'(tx - {1'b0, root_reg});
                        qx_reg   <= {qx_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        remx_reg <= tx[31:0];
                        qx_reg   <= {qx_reg[30:0], 1'b0};
                    end
                    if (ty >= {1'b0, root_reg})
                    begin
                        remy_reg <= 32'(ty - {1'b0, root_reg});
                        qy_reg   <= {qy_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        remy_reg <= ty[31:0];
                        qy_reg   <= {qy_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd31)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    res_reg   <= {res_reg.table_full, res_reg.done_res,
                                  res_reg.reached_index, res_reg.reached,
                                  sat_vel(dy_reg[32], qy_reg, ovfy_reg, mag_zero),
                                  sat_vel(dx_reg[32], qx_reg, ovfx_reg, mag_zero),
                                  res_reg.drive_valid};
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        out_reg      <= {res_reg.table_full, fin_reg,
                                         res_reg.reached_index, res_reg.reached,
                                         res_reg.velocity_y, res_reg.velocity_x,
                                         res_reg.drive_valid};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TOTAL_W'(MAX_WAYPOINTS))
        else $error("waypoint count beyond table size");

    a_index_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg != '0) |-> (TOTAL_W'(cur_reg) < total_reg))
        else $error("current index outside filled table");

    a_reached_drives: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (!out_reg.reached || out_reg.drive_valid))
        else $error("reached without a drive command");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_EXEC))
        else $error("accepted request not executed");

endmodule
